[design/utv_pkg.sv]
// Shared types and constants for the UTF-8 text validator.
package utv_pkg;

   localparam int unsigned LenWidth   = 10;
   localparam int unsigned CountWidth = LenWidth + 1;

   localparam logic [LenWidth-1:0] MaxLengthReset = LenWidth'(64);

   localparam logic [7:0] ContLow   = 8'h80;
   localparam logic [7:0] ContHigh  = 8'hBF;
   localparam logic [7:0] Space     = 8'h20;
   localparam logic [7:0] Delete    = 8'h7F;
   localparam logic [7:0] Lead2Low  = 8'hC2;
   localparam logic [7:0] Lead2High = 8'hDF;
   localparam logic [7:0] Lead3Low  = 8'hE0;
   localparam logic [7:0] Lead3High = 8'hEF;
   localparam logic [7:0] Lead3Surr = 8'hED;
   localparam logic [7:0] Lead4Low  = 8'hF0;
   localparam logic [7:0] Lead4High = 8'hF4;
   localparam logic [7:0] E0SecLow  = 8'hA0;
   localparam logic [7:0] EdSecHigh = 8'h9F;
   localparam logic [7:0] F0SecLow  = 8'h90;
   localparam logic [7:0] F4SecHigh = 8'h8F;

   // Per-text decode state.
   typedef struct packed {
      logic [1:0]            bytes_pending;
      logic [7:0]            next_low_bound;
      logic [7:0]            next_high_bound;
      logic [CountWidth-1:0] byte_count;
      logic                  failed;
      logic                  last_was_space;
   } utv_state_type;

   localparam utv_state_type StateClear = '{
      bytes_pending:   2'd0,
      next_low_bound:  ContLow,
      next_high_bound: ContHigh,
      byte_count:      '0,
      failed:          1'b0,
      last_was_space:  1'b0
   };

endpackage

[design/utf8_text_validator.sv]
// Top level of the streaming strict UTF-8 text validator.
//
// Checks a text delivered one word (one byte) per cycle as strict UTF-8:
// lead bytes 20-7E, C2-DF, E0-EF and F0-F4 with the narrowed second-byte
// ranges after E0, ED, F0 and F4; control bytes 00-1F and 7F fail, as does
// a leading or trailing space, a truncated sequence at the end, or a text
// longer than the length limit register (reset 64, written through csr_*).
// The word marked req_last yields one verdict word on rsp_valid_res, after
// which the decode state is cleared for the next text; a last word with
// req_has_byte low ends the text without adding a byte (an empty text is
// valid). Throughput is one word per cycle: the decode state updates in the
// same cycle a word is taken, and the verdict lands in the output register
// in the next cycle. Only a last word is held off by a full output register
// that the receiver is stalling; all other words keep flowing.
module utf8_text_validator
   import utv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_has_byte,
   input  logic                req_last,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_valid_res,

   input  logic                csr_wr_en,
   input  logic [LenWidth-1:0] csr_wr_data
);

   logic [LenWidth-1:0] len_limit_ff;
   utv_state_type       state_ff, state_in;
   utv_state_type       byte_state;   // state after this word's byte
   utv_state_type       end_state;    // state the verdict is taken from
   logic                rsp_valid_ff, rsp_valid_in;
   logic                verdict_ff, verdict_in;
   logic                req_take;
   logic                verdict;

   utv_byte_check u_byte_check (
      .cur_state  (state_ff),
      .data_byte  (req_data_byte),
      .len_limit  (len_limit_ff),
      .nxt_state  (byte_state)
   );

   // A last word needs a free output slot; slot frees when its word is taken.
   assign req_stall = req_last && rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   assign end_state = req_has_byte ? byte_state : state_ff;

   assign verdict = !end_state.failed &&
                    (end_state.bytes_pending == 2'd0) &&
                    !end_state.last_was_space &&
                    (end_state.byte_count <= {1'b0, len_limit_ff});

   always_comb begin
      state_in = state_ff;
      if (req_take) begin
         if (req_last) begin
            state_in = StateClear;
         end else if (req_has_byte) begin
            state_in = byte_state;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      verdict_in   = verdict_ff;
      if (req_take && req_last) begin
         rsp_valid_in = 1'b1;
         verdict_in   = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_limit_ff <= MaxLengthReset;
         state_ff     <= StateClear;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            len_limit_ff <= csr_wr_data;
         end
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload register, no reset needed.
   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = verdict_ff;

endmodule

[design/utv_byte_check.sv]
// Per-byte UTF-8 decode step: next text state from the current one and a byte.
module utv_byte_check
   import utv_pkg::*;
(
   input  utv_state_type        cur_state,
   input  logic [7:0]           data_byte,
   input  logic [LenWidth-1:0]  len_limit,
   output utv_state_type        nxt_state
);

   logic is_space;

   assign is_space = (data_byte == Space);

   always_comb begin
      nxt_state = cur_state;
      nxt_state.last_was_space = is_space;

      if ((cur_state.byte_count == '0) && is_space) begin
         nxt_state.failed = 1'b1;
      end
      // Count saturates one past the limit.
      if (cur_state.byte_count <= {1'b0, len_limit}) begin
         nxt_state.byte_count = cur_state.byte_count + CountWidth'(1);
      end

      if (cur_state.bytes_pending != 2'd0) begin
         // Continuation byte.
         if ((data_byte < cur_state.next_low_bound) ||
             (data_byte > cur_state.next_high_bound)) begin
            nxt_state.failed = 1'b1;
         end
         nxt_state.bytes_pending   = cur_state.bytes_pending - 2'd1;
         nxt_state.next_low_bound  = ContLow;
         nxt_state.next_high_bound = ContHigh;
      end else if (data_byte < ContLow) begin
         if ((data_byte < Space) || (data_byte == Delete)) begin
            nxt_state.failed = 1'b1;
         end
      end else if ((data_byte >= Lead2Low) && (data_byte <= Lead2High)) begin
         nxt_state.bytes_pending = 2'd1;
      end else if ((data_byte >= Lead3Low) && (data_byte <= Lead3High)) begin
         nxt_state.bytes_pending = 2'd2;
         if (data_byte == Lead3Low) begin
            nxt_state.next_low_bound = E0SecLow;
         end else if (data_byte == Lead3Surr) begin
            nxt_state.next_high_bound = EdSecHigh;
         end
      end else if ((data_byte >= Lead4Low) && (data_byte <= Lead4High)) begin
         nxt_state.bytes_pending = 2'd3;
         if (data_byte == Lead4Low) begin
            nxt_state.next_low_bound = F0SecLow;
         end else if (data_byte == Lead4High) begin
            nxt_state.next_high_bound = F4SecHigh;
         end
      end else begin
         // Stray continuation, overlong lead C0/C1, or F5-FF.
         nxt_state.failed = 1'b1;
      end
   end

endmodule
